// ===== hw/rtl/sliding_window_mean_and_count_macros.svh =====
// Assertion helpers used by the top-level RTL file.
// Both expect clk and arst_n to exist in the module that uses them.
`ifndef SLIDING_WINDOW_MEAN_AND_COUNT_MACROS_SVH
`define SLIDING_WINDOW_MEAN_AND_COUNT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
package swm_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// Configuration register map
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 8'd1;

	// Window length register
	localparam int               LEN_REG_W = 7;
	localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd16;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAIN,
		ST_DIV,
		ST_DONE
	} swm_state_t;

endpackage

// ===== hw/rtl/swm_cell.sv =====
`timescale 1ns / 1ps
module swm_cell import swm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int LENW        = 7,
	parameter int SUMW        = 22,
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic [SAMPLE_BITS-1:0] sample_out,
	input  logic [LENW-1:0]        fill,
	input  logic [SAMPLE_BITS-1:0] threshold,
	input  logic                   tok_valid_in,
	input  logic [LENW-1:0]        tok_cnt_in,
	input  logic [SUMW-1:0]        tok_sum_in,
	output logic                   tok_valid_out,
	output logic [LENW-1:0]        tok_cnt_out,
	output logic [SUMW-1:0]        tok_sum_out
);

	localparam logic [LENW-1:0] MY_IDX = LENW'(IDX);

	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   tok_valid_q;
	logic [LENW-1:0]        tok_cnt_q;
	logic [SUMW-1:0]        tok_sum_q;
	logic                   active;
	logic                   above;

	// Hold one sample; advance toward the far end on every push
	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= sample_in;
		end
	end

	// Only the newest fill entries belong to the window
	assign active = fill > MY_IDX;
	assign above  = $signed(sample_q) > $signed(threshold);

	// Add this cell's share to the passing token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid_in) begin
			tok_cnt_q <= tok_cnt_in + LENW'(active && above);
			tok_sum_q <= tok_sum_in + (active ? SUMW'($signed(sample_q)) : '0);
		end
	end

	assign sample_out    = sample_q;
	assign tok_valid_out = tok_valid_q;
	assign tok_cnt_out   = tok_cnt_q;
	assign tok_sum_out   = tok_sum_q;

endmodule

// ===== hw/rtl/swm_divider.sv =====
`timescale 1ns / 1ps
module swm_divider import swm_pkg::*; #(
	parameter int SUMW = 22,
	parameter int LENW = 7,
	parameter int QW   = SAMPLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SUMW-1:0] dividend,
	input  logic [LENW-1:0] divisor,
	output logic            done,
	output logic [QW-1:0]   quotient
);

	localparam int CW = $clog2(SUMW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [LENW-1:0] rem_q;
	logic [LENW-1:0] div_q;
	logic [SUMW-1:0] quo_q;
	logic            neg_q;
	logic [LENW:0]   trial;
	logic            fits;
	logic [SUMW-1:0] signed_quo;

	// Restoring division on the magnitude, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SUMW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[SUMW-1];
			quo_q <= dividend[SUMW-1] ? (~dividend + 1'b1) : dividend;
		end else if (busy_q) begin
			rem_q <= fits ? LENW'(trial - {1'b0, div_q}) : LENW'(trial);
			quo_q <= {quo_q[SUMW-2:0], fits};
		end
	end

	// Restore the sign; the magnitude always fits the sample width
	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed_quo[QW-1:0];
	assign done       = done_q;

endmodule

// ===== hw/rtl/sliding_window_mean_and_count.sv =====
`timescale 1ns / 1ps
// Sliding-window mean and threshold count.
// Input words arrive on s_axis_*: each carries one signed sample that is pushed
// into the window. Every accepted word yields exactly one result word on
// m_axis_*: the truncated window average (0 until the window is full), the
// number of held samples above the threshold, and a full flag.
// Registers are written on the cfg_* channel (index 0 window_length, index 1
// threshold); the user must write them only while the block is idle, which the
// block does not enforce. A window_length write empties the window. Samples sit
// in a row of MAX_WINDOW cells that shift on each push. A token then walks the
// row one cell per cycle, summing the held samples and counting those above the
// threshold, and a bit-serial divider works through the sum bit by bit. One word
// is in flight at a time and the input reopens in the cycle after the result
// loads, so a new word is not taken before the previous result has loaded.
// The next word is taken while a result still waits on a stalled
// receiver; the result register holds until m_axis_tready.
// Reset (arst_n low) empties the window, sets window_length to 16 and threshold
// to 0, and drops any pending result.
module sliding_window_mean_and_count import swm_pkg::*; #(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int LENW  = $clog2(MAX_WINDOW + 1),
	localparam int SUMW  = SAMPLE_BITS + $clog2(MAX_WINDOW),
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + LENW + 1 + 7) / 8) * 8,
	localparam int CFG_W = (SAMPLE_BITS > LEN_REG_W) ? SAMPLE_BITS : LEN_REG_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_W-1:0]      s_axis_tdata,  // sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_W-1:0]     m_axis_tdata,  // average, above_count, window_full
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	`include "sliding_window_mean_and_count_macros.svh"

	swm_state_t state_q, state_d;

	logic [LEN_REG_W-1:0]   win_len_q;
	logic [SAMPLE_BITS-1:0] thresh_q;
	logic [LENW-1:0]        eff_len;
	logic [LENW-1:0]        fill_q;
	logic                   full_q;
	logic                   tok_start_q;
	logic [LENW-1:0]        cnt_res_q;
	logic                   in_accept;
	logic                   cfg_accept;
	logic                   div_start;
	logic                   div_done;
	logic [SAMPLE_BITS-1:0] div_quo;
	logic                   out_load;
	logic                   m_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [LENW-1:0]        cnt_out_q;
	logic                   full_out_q;

	logic [SAMPLE_BITS-1:0] cell_sample [MAX_WINDOW+1];
	logic                   tok_valid   [MAX_WINDOW+1];
	logic [LENW-1:0]        tok_cnt     [MAX_WINDOW+1];
	logic [SUMW-1:0]        tok_sum     [MAX_WINDOW+1];

	assign in_accept  = s_axis_tvalid && s_axis_tready;
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	// Clamp the length register to the supported range
	always_comb begin
		if (win_len_q == '0) begin
			eff_len = LENW'(1);
		end else if (32'(win_len_q) > MAX_WINDOW) begin
			eff_len = LENW'(MAX_WINDOW);
		end else begin
			eff_len = LENW'(win_len_q);
		end
	end

	// Configuration registers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= LEN_RESET;
			thresh_q  <= '0;
			fill_q    <= '0;
			full_q    <= 1'b0;
		end else begin
			if (cfg_accept && cfg_index == REG_WINDOW_LENGTH) begin
				win_len_q <= cfg_data[LEN_REG_W-1:0];
				fill_q    <= '0;
			end else if (in_accept) begin
				if (fill_q != eff_len) begin
					fill_q <= fill_q + 1'b1;
				end
				full_q <= (fill_q == eff_len) || (fill_q + 1'b1 == eff_len);
			end
			if (cfg_accept && cfg_index == REG_THRESHOLD) begin
				thresh_q <= cfg_data[SAMPLE_BITS-1:0];
			end
		end
	end

	// Launch the summing token once the new sample has shifted in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_start_q <= 1'b0;
		end else begin
			tok_start_q <= in_accept;
		end
	end

	assign cell_sample[0] = s_axis_tdata[SAMPLE_BITS-1:0];
	assign tok_valid[0]   = tok_start_q;
	assign tok_cnt[0]     = '0;
	assign tok_sum[0]     = '0;

	// Row of sample cells
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.LENW       (LENW),
			.SUMW       (SUMW),
			.IDX        (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.shift        (in_accept),
			.sample_in    (cell_sample[i]),
			.sample_out   (cell_sample[i+1]),
			.fill         (fill_q),
			.threshold    (thresh_q),
			.tok_valid_in (tok_valid[i]),
			.tok_cnt_in   (tok_cnt[i]),
			.tok_sum_in   (tok_sum[i]),
			.tok_valid_out(tok_valid[i+1]),
			.tok_cnt_out  (tok_cnt[i+1]),
			.tok_sum_out  (tok_sum[i+1])
		);
	end

	// Hold the count while the divider runs
	always_ff @(posedge clk) begin
		if (tok_valid[MAX_WINDOW]) begin
			cnt_res_q <= tok_cnt[MAX_WINDOW];
		end
	end

	swm_divider #(
		.SUMW(SUMW),
		.LENW(LENW),
		.QW  (SAMPLE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(tok_sum[MAX_WINDOW]),
		.divisor (eff_len),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_CHAIN;
				end
			end
			ST_CHAIN: begin
				if (tok_valid[MAX_WINDOW]) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result register; hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q      <= full_q ? div_quo : '0;
			cnt_out_q  <= cnt_res_q;
			full_out_q <= full_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'({full_out_q, cnt_out_q, avg_q});

	`SWM_ASSERT_ALWAYS(a_fill_in_range, fill_q <= eff_len, "fill level beyond window length")
	`SWM_ASSERT_ALWAYS(a_token_in_chain, !tok_valid[MAX_WINDOW] || state_q == ST_CHAIN,
		"token left the chain outside the sweep")
	`SWM_ASSERT_ALWAYS(a_div_done_in_div, !div_done || state_q == ST_DIV,
		"divider finished outside the divide step")
	`SWM_ASSERT_NEXT(a_load_shows, out_load, m_valid_q, "loaded result not presented")

endmodule
